// File: hw/rtl/frr_pkg.sv
`default_nettype none

package frr_pkg;

   localparam int TIME_W = 64;
   localparam int LEN_W = 24;
   localparam int RATE_W = 10;
   localparam int DIV_W = RATE_W + 1;
   localparam int CARRY_W = DIV_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W = CSR_ADDR_W - 2;

   localparam int FRR_MAX_REPEATS = 64;
   localparam int FRR_CMD_DEPTH = 2;
   localparam int FRR_RSP_DEPTH = 2;

   localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = LEN_W'(400000);
   localparam logic [RATE_W-1:0] FRAC_STEP_RESET = RATE_W'(0);
   localparam logic [RATE_W-1:0] FRAME_RATE_RESET = RATE_W'(25);

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAC_STEP = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_RATE = CSR_IDX_W'(2);

   typedef enum logic {
      CMD_PASS,
      CMD_MEDIA
   } cmd_kind_type;

   typedef struct packed {
      logic is_media;
      logic signed [TIME_W-1:0] sample_stop;
   } req_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] frame_start;
      logic signed [TIME_W-1:0] frame_stop;
      logic passthrough;
      logic truncated;
      logic last_of_run;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [TIME_W-1:0] sample_stop;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] frame_length;
      logic [RATE_W-1:0] frac_step;
      logic [RATE_W-1:0] frame_rate;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/frame_rate_retimer.sv
`default_nettype none

// Retimes video sample events to a fixed output frame rate. A non-media beat
// yields one passthrough result; a media beat yields one output frame per
// frame period that ends at or before its stop time, up to MAX_REPEATS, with
// last_of_run on the final one. Input beats enter a command queue and results
// leave through a result queue, so both sides stall independently. While the
// result queue is not full, the frame engine emits one frame per cycle (two
// 64-bit adds and a compare per frame). After reset and after a write to
// frac_step or frame_rate the next media beat first goes through the serial
// divider to split the step; another division follows whenever the stored
// remainder is not below the frame rate. No clearing pass follows reset.
module frame_rate_retimer #(
   parameter int MAX_REPEATS = frr_pkg::FRR_MAX_REPEATS,
   parameter int CMD_DEPTH = frr_pkg::FRR_CMD_DEPTH,
   parameter int RSP_DEPTH = frr_pkg::FRR_RSP_DEPTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire frr_pkg::req_type req_data,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output frr_pkg::rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [frr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [frr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [frr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   import frr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic ratio_stale;

   cmd_type cmd_push_data;
   cmd_type cmd_head;
   logic [$bits(cmd_type)-1:0] cmd_head_bits;
   logic cmd_empty;
   logic cmd_pop;

   rsp_type out_data;
   logic out_push;
   logic out_full;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign ratio_stale = csr_wr && ((csr_idx == REG_FRAC_STEP) || (csr_idx == REG_FRAME_RATE));

   always_comb begin
      cfg_in = cfg_ff;
      csr_prdata = '0;
      case (csr_idx)
         REG_FRAME_LENGTH: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.frame_length);
            if (csr_wr) begin
               cfg_in.frame_length = csr_pwdata[LEN_W-1:0];
            end
         end
         REG_FRAC_STEP: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.frac_step);
            if (csr_wr) begin
               cfg_in.frac_step = csr_pwdata[RATE_W-1:0];
            end
         end
         REG_FRAME_RATE: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.frame_rate);
            if (csr_wr) begin
               cfg_in.frame_rate = csr_pwdata[RATE_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length <= FRAME_LENGTH_RESET;
         cfg_ff.frac_step <= FRAC_STEP_RESET;
         cfg_ff.frame_rate <= FRAME_RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cmd_push_data.kind = req_data.is_media ? CMD_MEDIA : CMD_PASS;
      cmd_push_data.sample_stop = req_data.sample_stop;
   end

   frr_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .full(req_full),
      .push_data(cmd_push_data),
      .pop(cmd_pop),
      .empty(cmd_empty),
      .pop_data(cmd_head_bits)
   );

   assign cmd_head = cmd_type'(cmd_head_bits);

   frr_back #(
      .MAX_REPEATS(MAX_REPEATS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .ratio_stale(ratio_stale),
      .cmd_empty(cmd_empty),
      .cmd(cmd_head),
      .cmd_pop(cmd_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_data(out_data)
   );

   frr_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .full(out_full),
      .push_data(out_data),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .pop_data(rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

`default_nettype wire

// File: hw/rtl/frr_fifo.sv
`default_nettype none

module frr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   output logic full,
   input wire logic [WIDTH-1:0] push_data,
   input wire logic pop,
   output logic empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push;
   logic do_pop;

   assign full = (cnt_ff == CNT_FULL);
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/frr_div.sv
`default_nettype none

module frr_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [frr_pkg::DIV_W-1:0] dividend,
   input wire logic [frr_pkg::RATE_W-1:0] divisor,
   output logic done,
   output logic [frr_pkg::DIV_W-1:0] quotient,
   output logic [frr_pkg::RATE_W-1:0] remainder
);

   import frr_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(DIV_W - 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [RATE_W-1:0] part_ff, part_in;
   logic [RATE_W-1:0] dsr_ff, dsr_in;
   logic [DIV_W-1:0] trial;
   logic [DIV_W-1:0] diff;
   logic ge;

   assign done = done_ff;
   assign quotient = quot_ff;
   assign remainder = part_ff;

   always_comb begin
      trial = {part_ff, quot_ff[DIV_W-1]};
      ge = (trial >= {1'b0, dsr_ff});
      diff = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quot_in = quot_ff;
      part_in = part_ff;
      dsr_in = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_FIRST;
         quot_in = dividend;
         part_in = '0;
         dsr_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_W-2:0], ge};
         part_in = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      part_ff <= part_in;
      dsr_ff <= dsr_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/frr_back.sv
`default_nettype none

module frr_back #(
   parameter int MAX_REPEATS = frr_pkg::FRR_MAX_REPEATS
) (
   input wire logic clock,
   input wire logic reset,
   input wire frr_pkg::cfg_type cfg,
   input wire logic ratio_stale,
   input wire logic cmd_empty,
   input wire frr_pkg::cmd_type cmd,
   output logic cmd_pop,
   input wire logic out_full,
   output logic out_push,
   output frr_pkg::rsp_type out_data
);

   import frr_pkg::*;

   localparam int CNT_W = $clog2(MAX_REPEATS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REPEATS);
   localparam logic [TIME_W-1:0] TIME_SIGN = {1'b1, {(TIME_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_FRAC,
      ST_DIV_REM,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic qf_valid_ff, qf_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pend_valid_ff, pend_valid_in;
   logic [TIME_W-1:0] stop_ff, stop_in;
   logic [DIV_W-1:0] qf_ff, qf_in;
   logic [RATE_W-1:0] rf_ff, rf_in;
   logic [DIV_W-1:0] extra_ff, extra_in;
   logic [RATE_W-1:0] wrem_ff, wrem_in;
   logic [TIME_W-1:0] pend_start_ff, pend_start_in;
   logic [TIME_W-1:0] pend_stop_ff, pend_stop_in;

   logic div_start;
   logic [DIV_W-1:0] div_dividend;
   logic div_done;
   logic [DIV_W-1:0] div_q;
   logic [RATE_W-1:0] div_r;

   logic [RATE_W-1:0] rate_eff;
   logic rem_big;
   logic [TIME_W:0] fit_sum;
   logic fit_next;
   logic can_emit;
   logic [DIV_W-1:0] step_sum;
   logic step_ge;
   logic [DIV_W-1:0] step_diff;
   logic [RATE_W-1:0] rem_new;
   logic [CARRY_W-1:0] carry;
   logic [LEN_W:0] len_carry;
   logic [TIME_W:0] stop_sum;
   logic [TIME_W-1:0] stop_calc;

   frr_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(rate_eff),
      .done(div_done),
      .quotient(div_q),
      .remainder(div_r)
   );

   always_comb begin
      rate_eff = (cfg.frame_rate == '0) ? RATE_W'(1) : cfg.frame_rate;
      rem_big = (rem_ff >= rate_eff);
      fit_sum = {1'b0, next_ff} + (TIME_W+1)'(cfg.frame_length);
      fit_next = (fit_sum <= {1'b0, stop_ff});
      can_emit = fit_next && (count_ff != CNT_MAX);
      step_sum = {1'b0, wrem_ff} + {1'b0, rf_ff};
      step_ge = (step_sum >= {1'b0, rate_eff});
      step_diff = step_sum - {1'b0, rate_eff};
      rem_new = step_ge ? step_diff[RATE_W-1:0] : step_sum[RATE_W-1:0];
      carry = {1'b0, qf_ff} + {1'b0, extra_ff} + CARRY_W'(step_ge);
      len_carry = {1'b0, cfg.frame_length} + (LEN_W+1)'(carry);
      stop_sum = {1'b0, next_ff} + (TIME_W+1)'(len_carry);
      stop_calc = stop_sum[TIME_W] ? '1 : stop_sum[TIME_W-1:0];

      state_in = state_ff;
      next_in = next_ff;
      rem_in = rem_ff;
      qf_valid_in = qf_valid_ff;
      count_in = count_ff;
      pend_valid_in = pend_valid_ff;
      stop_in = stop_ff;
      qf_in = qf_ff;
      rf_in = rf_ff;
      extra_in = extra_ff;
      wrem_in = wrem_ff;
      pend_start_in = pend_start_ff;
      pend_stop_in = pend_stop_ff;
      cmd_pop = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      div_start = 1'b0;
      div_dividend = {1'b0, cfg.frac_step};

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.kind == CMD_PASS) begin
                  if (!out_full) begin
                     cmd_pop = 1'b1;
                     out_push = 1'b1;
                     out_data.passthrough = 1'b1;
                     out_data.last_of_run = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  stop_in = cmd.sample_stop ^ TIME_SIGN;
                  count_in = '0;
                  pend_valid_in = 1'b0;
                  if (!qf_valid_ff) begin
                     div_start = 1'b1;
                     div_dividend = {1'b0, cfg.frac_step};
                     state_in = ST_DIV_FRAC;
                  end else if (rem_big) begin
                     div_start = 1'b1;
                     div_dividend = {1'b0, rem_ff};
                     state_in = ST_DIV_REM;
                  end else begin
                     extra_in = '0;
                     wrem_in = rem_ff;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_DIV_FRAC: begin
            if (div_done) begin
               qf_in = div_q;
               rf_in = div_r;
               qf_valid_in = 1'b1;
               if (rem_big) begin
                  div_start = 1'b1;
                  div_dividend = {1'b0, rem_ff};
                  state_in = ST_DIV_REM;
               end else begin
                  extra_in = '0;
                  wrem_in = rem_ff;
                  state_in = ST_RUN;
               end
            end
         end
         ST_DIV_REM: begin
            if (div_done) begin
               extra_in = div_q;
               wrem_in = div_r;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!pend_valid_ff || !out_full) begin
               if (pend_valid_ff) begin
                  out_push = 1'b1;
                  out_data.frame_start = $signed(pend_start_ff ^ TIME_SIGN);
                  out_data.frame_stop = $signed(pend_stop_ff ^ TIME_SIGN);
                  out_data.last_of_run = !can_emit;
                  out_data.truncated = !can_emit && fit_next && (count_ff == CNT_MAX);
               end
               if (can_emit) begin
                  pend_valid_in = 1'b1;
                  pend_start_in = next_ff;
                  pend_stop_in = stop_calc;
                  next_in = stop_calc;
                  count_in = count_ff + CNT_W'(1);
                  wrem_in = rem_new;
                  rem_in = rem_new;
                  extra_in = '0;
               end else begin
                  pend_valid_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ratio_stale) begin
         qf_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_ff <= TIME_SIGN;
         rem_ff <= '0;
         qf_valid_ff <= 1'b0;
         count_ff <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         next_ff <= next_in;
         rem_ff <= rem_in;
         qf_valid_ff <= qf_valid_in;
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
      stop_ff <= stop_in;
      qf_ff <= qf_in;
      rf_ff <= rf_in;
      extra_ff <= extra_in;
      wrem_ff <= wrem_in;
      pend_start_ff <= pend_start_in;
      pend_stop_ff <= pend_stop_in;
   end

endmodule

`default_nettype wire
